// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check a property on a given clock, disabled while reset is low
`define ASSERT_AT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// same check on the usual clk / arst_n pair
`define ASSERT_DEF(lbl, prop, msg) \
	`ASSERT_AT(lbl, clk, arst_n, prop, msg)

`else

`define ASSERT_AT(lbl, clk_s, rst_n_s, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)

`endif

`endif

// ===== rtl/lkv_pkg.sv =====
// types and constants for the lru key-value cache
// used by the interfaces, the cell and the top level; no dependencies
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OPC_GET = 1'b0;
	localparam logic OPC_PUT = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HIT,
		OP_EVICT,
		OP_INSERT
	} op_kind_t;

	// broadcast to every cell for the word being processed
	typedef struct packed {
		op_kind_t             kind;
		logic                 put;
		logic [VAL_W-1:0]     value;
		logic [RANK_W-1:0]    old_rank;
	} cell_cmd_t;

	// passed from one cell to the next
	typedef struct packed {
		logic                 hit;
		logic [VAL_W-1:0]     value;
		logic [RANK_W-1:0]    rank;
		logic                 all_valid;
	} chain_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic target;
	} cell_stat_t;

endpackage

// ===== rtl/lkv_req_if.sv =====
// request channel: opcode, key and value with valid/ready
// depends on lkv_pkg
interface lkv_req_if;
	import lkv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [KEY_W-1:0]  lookup_key;
	logic signed [VAL_W-1:0]  write_value;

	modport source (output valid, output opcode, output lookup_key, output write_value,
		input ready);
	modport sink (input valid, input opcode, input lookup_key, input write_value,
		output ready);
endinterface

// ===== rtl/lkv_rsp_if.sv =====
// response channel: read value and found flag with valid/ready
// depends on lkv_pkg
interface lkv_rsp_if;
	import lkv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  read_value;
	logic                     found;

	modport source (output valid, output read_value, output found, input ready);
	modport sink (input valid, input read_value, input found, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
// one cache entry: key, value, valid bit and recency rank
// depends on lkv_pkg; chained by the top level
module lkv_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lkv_pkg::KEY_W-1:0] lookup_key,
	input  lkv_pkg::cell_cmd_t        cmd,
	input  lkv_pkg::chain_t           chain_in,
	output lkv_pkg::chain_t           chain_out,
	output lkv_pkg::cell_stat_t       stat
);
	import lkv_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [RANK_W-1:0] rank_q;
	logic              valid_q;
	logic              match;
	logic              target;

	assign match = valid_q && (key_q == lookup_key);

	always_comb begin
		chain_out.hit       = chain_in.hit | match;
		chain_out.value     = match ? value_q : chain_in.value;
		chain_out.rank      = match ? rank_q : chain_in.rank;
		chain_out.all_valid = chain_in.all_valid & valid_q;
	end

	always_comb begin
		case (cmd.kind)
			OP_HIT:    target = match;
			OP_EVICT:  target = valid_q && (rank_q == cmd.old_rank);
			// first free cell: every cell before it is valid
			OP_INSERT: target = !valid_q && chain_in.all_valid;
			default:   target = 1'b0;
		endcase
	end

	assign stat = '{valid: valid_q, hit: match, target: target};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (target) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (target) begin
			key_q  <= lookup_key;
			rank_q <= '0;
			if (cmd.put) begin
				value_q <= cmd.value;
			end
		end else if (cmd.kind != OP_NONE && valid_q && rank_q < cmd.old_rank) begin
			rank_q <= rank_q + RANK_W'(1);
		end
	end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// lru key-value cache: a row of entry cells with least-recently-used replacement.
// channels: req (opcode, lookup_key, write_value) in, rsp (read_value, found) out,
// both valid/ready; a word moves on a clock edge with valid and ready high.
// config: cfg_we / cfg_wdata write the capacity (0 acts as 1, above 16 acts as 16);
// write it only while no request is in flight.
// a get returns the stored value and found=1 on a hit, -1 and found=0 on a miss;
// a put returns 0 and found tells whether the key was already present.
// the response is registered and valid in the cycle after the request is accepted.
// throughput: one request per cycle while the receiver takes responses; the key compare,
// hit readout along the cell chain and the rank update of all cells happen in the accepting cycle.
// the response sits in an output register; req.ready stays high while that
// register is empty or being taken, so a stalled receiver holds one response
// and stops further requests until it takes it.
// reset: the cache is empty (all valid bits cleared), capacity is 16,
// no response is pending. no clearing pass is needed.
// depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_cell, assert_macros.svh
`include "assert_macros.svh"

module lru_key_value_cache_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
	lkv_req_if.sink                   req,
	lkv_rsp_if.source                 rsp
);
	import lkv_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	logic [VAL_W-1:0]  read_value_q;
	logic              found_q;

	logic              accept;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  cap_eff;
	logic              full;
	cell_cmd_t         cmd;
	chain_t            chain [ENTRIES+1];
	cell_stat_t        stat [ENTRIES];
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] target_vec;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// clamp capacity to 1..ENTRIES
	assign cap_ext = CMP_W'(cap_q);
	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign full = CMP_W'(count_q) >= cap_eff;

	assign chain[0] = '{hit: 1'b0, value: '1, rank: '0, all_valid: 1'b1};

	always_comb begin
		cmd.put   = req.opcode == OPC_PUT;
		cmd.value = req.write_value;
		if (!accept) begin
			cmd.kind     = OP_NONE;
			cmd.old_rank = '0;
		end else if (chain[ENTRIES].hit) begin
			cmd.kind     = OP_HIT;
			cmd.old_rank = chain[ENTRIES].rank;
		end else if (req.opcode == OPC_GET) begin
			cmd.kind     = OP_NONE;
			cmd.old_rank = '0;
		end else if (full) begin
			// least recent entry holds rank count-1
			cmd.kind     = OP_EVICT;
			cmd.old_rank = RANK_W'(count_q - CNT_W'(1));
		end else begin
			cmd.kind     = OP_INSERT;
			cmd.old_rank = RANK_W'(count_q);
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.lookup_key (req.lookup_key),
			.cmd        (cmd),
			.chain_in   (chain[g]),
			.chain_out  (chain[g+1]),
			.stat       (stat[g])
		);
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_vec[i]  = stat[i].valid;
			hit_vec[i]    = stat[i].hit;
			target_vec[i] = stat[i].target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.kind == OP_INSERT) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q      <= chain[ENTRIES].hit;
			read_value_q <= (req.opcode == OPC_PUT) ? '0 : chain[ENTRIES].value;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.found      = found_q;

	// keys of valid entries are distinct
	`ASSERT_DEF(a_hit_unique, $onehot0(hit_vec), "more than one entry matched the key")
	// every update hits exactly one cell
	`ASSERT_DEF(a_one_target, (cmd.kind != OP_NONE) |-> $onehot(target_vec), "update target not unique")
	// valid cells fill from the bottom and match the fill count
	`ASSERT_DEF(a_valid_packed, ((valid_vec & (valid_vec + ENTRIES'(1))) == '0), "valid entries not contiguous")
	`ASSERT_DEF(a_count_match, ($countones(valid_vec) == int'(count_q)), "fill count disagrees with valid bits")
	`ASSERT_DEF(a_insert_count, (cmd.kind == OP_INSERT) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow fill")

endmodule
